/* src/arpc_pkg.sv */
`default_nettype none
package arpc_pkg;

    localparam int unsigned IP_W   = 32;
    localparam int unsigned MAC_W  = 48;
    localparam int unsigned TMR_W  = 8;
    localparam int unsigned RTY_W  = 4;
    localparam int unsigned CFG_W  = 8;
    localparam int unsigned CIDX_W = 2;

    localparam int unsigned IN_DATA_W  = 80;
    localparam int unsigned OUT_DATA_W = 88;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_UPDATE  = 2'd1,
        OP_RESOLVE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_FREE      = 2'd0,
        MODE_VALID     = 2'd1,
        MODE_RESOLVING = 2'd2
    } t_mode;

    localparam logic [CIDX_W-1:0] CFG_VALID_TIMEOUT   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_RESOLVE_TIMEOUT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MAX_RETRIES     = 2'd2;

    localparam logic [TMR_W-1:0] VALID_TIMEOUT_RST   = 8'd10;
    localparam logic [TMR_W-1:0] RESOLVE_TIMEOUT_RST = 8'd5;
    localparam logic [RTY_W-1:0] MAX_RETRIES_RST     = 4'd3;

    typedef struct packed {
        logic [1:0]       entry_status;
        logic [IP_W-1:0]  request_ip;
        logic             send_request;
        logic [MAC_W-1:0] mac_out;
        logic             hit;
    } t_result;

endpackage
`default_nettype wire

/* src/arpc_entry.sv */
`default_nettype none
module arpc_entry (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [arpc_pkg::CIDX_W-1:0]   i_cfg_addr,
    input  wire logic [arpc_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic                          i_en,
    input  wire logic [1:0]                    i_op,
    input  wire logic [arpc_pkg::IP_W-1:0]     i_ip,
    input  wire logic [arpc_pkg::MAC_W-1:0]    i_mac,
    output arpc_pkg::t_result                  o_res
);
    import arpc_pkg::*;

    logic [TMR_W-1:0] r_valid_timeout;
    logic [TMR_W-1:0] r_resolve_timeout;
    logic [RTY_W-1:0] r_max_retries;

    t_mode            r_mode,    n_mode;
    logic [IP_W-1:0]  r_ip,      n_ip;
    logic [MAC_W-1:0] r_mac,     n_mac;
    logic [TMR_W-1:0] r_time,    n_time;
    logic [RTY_W-1:0] r_retries, n_retries;

    logic expire;
    logic ip_match;

    assign expire   = (r_time <= TMR_W'(1));
    assign ip_match = (r_ip == i_ip);

    always_comb begin
        n_mode    = r_mode;
        n_ip      = r_ip;
        n_mac     = r_mac;
        n_time    = r_time;
        n_retries = r_retries;
        o_res     = '0;

        case (t_op'(i_op))
            OP_TICK: begin
                unique case (r_mode)
                    MODE_RESOLVING: begin
                        n_time = expire ? '0 : r_time - TMR_W'(1);
                        if (expire) begin
                            if (r_retries == '0) begin
                                n_mode = MODE_FREE;
                            end else begin
                                n_retries          = r_retries - RTY_W'(1);
                                n_time             = r_resolve_timeout;
                                o_res.send_request = 1'b1;
                                o_res.request_ip   = r_ip;
                            end
                        end
                    end
                    MODE_VALID: begin
                        n_time = expire ? '0 : r_time - TMR_W'(1);
                        if (expire) begin
                            // expired pair: ask again, keep the retry budget
                            n_mode             = MODE_RESOLVING;
                            n_time             = r_resolve_timeout;
                            o_res.send_request = 1'b1;
                            o_res.request_ip   = r_ip;
                        end
                    end
                    default: ;
                endcase
            end
            OP_UPDATE: begin
                n_ip      = i_ip;
                n_mac     = i_mac;
                n_mode    = MODE_VALID;
                n_time    = r_valid_timeout;
                n_retries = r_max_retries;
            end
            OP_RESOLVE: begin
                if (r_mode == MODE_VALID && ip_match) begin
                    o_res.hit     = 1'b1;
                    o_res.mac_out = r_mac;
                end else if (!(r_mode == MODE_RESOLVING && ip_match)) begin
                    // miss: take over the entry and start resolving
                    n_ip               = i_ip;
                    n_mode             = MODE_RESOLVING;
                    n_time             = r_resolve_timeout;
                    n_retries          = r_max_retries;
                    o_res.send_request = 1'b1;
                    o_res.request_ip   = i_ip;
                end
            end
            default: ;
        endcase

        o_res.entry_status = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_timeout   <= VALID_TIMEOUT_RST;
            r_resolve_timeout <= RESOLVE_TIMEOUT_RST;
            r_max_retries     <= MAX_RETRIES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_VALID_TIMEOUT:   r_valid_timeout   <= i_cfg_data;
                CFG_RESOLVE_TIMEOUT: r_resolve_timeout <= i_cfg_data;
                CFG_MAX_RETRIES:     r_max_retries     <= i_cfg_data[RTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_FREE;
            r_ip      <= '0;
            r_time    <= '0;
            r_retries <= '0;
        end else if (i_en) begin
            r_mode    <= n_mode;
            r_ip      <= n_ip;
            r_time    <= n_time;
            r_retries <= n_retries;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mac <= n_mac;
        end
    end

endmodule
`default_nettype wire

/* src/arp_entry_cache_timer.sv */
// An input transfer passes the input register, then the entry update logic and
// the result register, before its result shows on the master side.
// Throughput: one item per cycle while m_axis_tready does not stall the output.
// Reset (synchronous, active low): entry free, address and timers cleared,
// registers back to valid_timeout 10, resolve_timeout 5, max_retries 3.
`default_nettype none
module arp_entry_cache_timer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [arpc_pkg::CIDX_W-1:0]       i_cfg_addr,
    input  wire logic [arpc_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    // ip_addr[31:0], hw_addr[79:32]
    input  wire logic [arpc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // operation[1:0]
    input  wire logic [1:0]                        s_axis_tuser,
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // hit[0], mac_out[48:1], send_request[49], request_ip[81:50],
    // entry_status[83:82], zero[87:84]
    output      logic [arpc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import arpc_pkg::*;

    logic             r_in_valid;
    logic [1:0]       r_in_op;
    logic [IP_W-1:0]  r_in_ip;
    logic [MAC_W-1:0] r_in_mac;
    logic             r_out_valid;
    t_result          r_out;
    t_result          res;
    logic             advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    arpc_entry u_entry (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_en       (advance),
        .i_op       (r_in_op),
        .i_ip       (r_in_ip),
        .i_mac      (r_in_mac),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op  <= s_axis_tuser;
            r_in_ip  <= s_axis_tdata[IP_W-1:0];
            r_in_mac <= s_axis_tdata[IP_W +: MAC_W];
        end
        if (advance) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - $bits(t_result)){1'b0}}, r_out};

endmodule
`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;
    import arpc_pkg::*;

    localparam int CYCLE_LIMIT  = 250000;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 142;
    localparam int LONG_HOLD    = 250;
    localparam int DRAIN_CYCLES = 4;

    // index past the last register, must be ignored
    localparam logic [CIDX_W-1:0] CFG_NO_REG = 2'd3;

    typedef enum bit {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        t_op               op;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        bit                typed;
        t_result           want;
        logic [CIDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]  reg_val;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CIDX_W-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // entry state as the cache should hold it
    t_mode ent_mode;
    logic [IP_W-1:0] ent_ip;
    logic [MAC_W-1:0] ent_mac;
    logic [TMR_W-1:0] ttl;
    logic [RTY_W-1:0] tries_left;
    logic [TMR_W-1:0] cfg_valid_to;
    logic [TMR_W-1:0] cfg_resolve_to;
    logic [RTY_W-1:0] cfg_retries;

    t_result answers_due[$];
    t_dir_row dir_rows[$];
    int mismatch_cnt = 0;
    int results_seen = 0;
    int cycle_cnt = 0;
    int hold_left = 0;
    bit hold_off_req = 1'b0;
    bit src_gaps = 1'b1;
    bit sink_stalls = 1'b1;

    arp_entry_cache_timer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_result arp_entry_step(input t_op op, input logic [IP_W-1:0] ip,
                                               input logic [MAC_W-1:0] mac);
        t_result r;
        bit expired;
        r = '0;
        expired = 1'b0;
        case (op)
            OP_TICK: begin
                if (ent_mode != MODE_FREE) begin
                    expired = (ttl <= 8'd1);
                    ttl = expired ? 8'd0 : ttl - 8'd1;
                end
                if (expired) begin
                    if (ent_mode == MODE_RESOLVING && tries_left == '0) begin
                        ent_mode = MODE_FREE;
                    end else begin
                        // a valid entry keeps its retry budget on expiry
                        if (ent_mode == MODE_RESOLVING)
                            tries_left = tries_left - 4'd1;
                        ent_mode = MODE_RESOLVING;
                        ttl = cfg_resolve_to;
                        r.send_request = 1'b1;
                        r.request_ip = ent_ip;
                    end
                end
            end
            OP_UPDATE: begin
                ent_ip = ip;
                ent_mac = mac;
                ent_mode = MODE_VALID;
                ttl = cfg_valid_to;
                tries_left = cfg_retries;
            end
            OP_RESOLVE: begin
                if (ent_mode == MODE_VALID && ent_ip == ip) begin
                    r.hit = 1'b1;
                    r.mac_out = ent_mac;
                end else if (!(ent_mode == MODE_RESOLVING && ent_ip == ip)) begin
                    ent_ip = ip;
                    ent_mode = MODE_RESOLVING;
                    ttl = cfg_resolve_to;
                    tries_left = cfg_retries;
                    r.send_request = 1'b1;
                    r.request_ip = ip;
                end
            end
            default: begin
            end
        endcase
        r.entry_status = ent_mode;
        return r;
    endfunction

    function automatic t_dir_row item_row(input t_op op, input logic [IP_W-1:0] ip,
                                          input logic [MAC_W-1:0] mac);
        t_dir_row row;
        row = '{kind: ROW_ITEM, op: op, ip: ip, mac: mac, typed: 1'b0, want: '0,
                reg_idx: '0, reg_val: '0};
        return row;
    endfunction

    function automatic t_dir_row known_row(input t_op op, input logic [IP_W-1:0] ip,
                                           input logic [MAC_W-1:0] mac, input t_mode st,
                                           input logic send, input logic [IP_W-1:0] rip,
                                           input logic hit, input logic [MAC_W-1:0] mac_o);
        t_dir_row row;
        row = item_row(op, ip, mac);
        row.typed = 1'b1;
        row.want.entry_status = st;
        row.want.send_request = send;
        row.want.request_ip = rip;
        row.want.hit = hit;
        row.want.mac_out = mac_o;
        return row;
    endfunction

    function automatic t_dir_row reg_row(input logic [CIDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] val);
        t_dir_row row;
        row = item_row(OP_NONE, '0, '0);
        row.kind = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: result %0d: %s", $time, results_seen, msg);
        mismatch_cnt++;
    endtask

    task automatic check_field(input string name, input logic [MAC_W-1:0] got,
                               input logic [MAC_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic push_item(input t_op op, input logic [IP_W-1:0] ip,
                             input logic [MAC_W-1:0] mac, input bit typed,
                             input t_result want);
        t_result due;
        if (src_gaps && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {mac, ip};
        s_axis_tuser <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        due = arp_entry_step(op, ip, mac);
        answers_due.push_back(typed ? want : due);
        @(negedge i_clk);
    endtask

    // write only once the cache has gone quiet
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        s_axis_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_VALID_TIMEOUT)
            cfg_valid_to = val;
        else if (idx == CFG_RESOLVE_TIMEOUT)
            cfg_resolve_to = val;
        else if (idx == CFG_MAX_RETRIES)
            cfg_retries = val[RTY_W-1:0];
    endtask

    always @(negedge i_clk) begin
        if (hold_off_req) begin
            hold_left = LONG_HOLD;
            hold_off_req = 1'b0;
        end else if (hold_left == 0 && sink_stalls && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(1, 19);
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[$bits(t_result)-1:0];
            results_seen++;
            if (answers_due.size() == 0) begin
                report_mismatch("transfer with no result due");
            end else begin
                want = answers_due.pop_front();
                check_field("hit", MAC_W'(got.hit), MAC_W'(want.hit));
                check_field("mac_out", got.mac_out, want.mac_out);
                check_field("send_request", MAC_W'(got.send_request),
                            MAC_W'(want.send_request));
                check_field("request_ip", MAC_W'(got.request_ip), MAC_W'(want.request_ip));
                check_field("entry_status", MAC_W'(got.entry_status),
                            MAC_W'(want.entry_status));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [IP_W-1:0] ip_pool [4];
        logic [IP_W-1:0] ip;
        logic [63:0] wide;
        t_op op;
        int pick;

        ent_mode = MODE_FREE;
        ent_ip = '0;
        ent_mac = '0;
        ttl = '0;
        tries_left = '0;
        cfg_valid_to = VALID_TIMEOUT_RST;
        cfg_resolve_to = RESOLVE_TIMEOUT_RST;
        cfg_retries = MAX_RETRIES_RST;
        ip_pool = '{32'hC0A8_0001, 32'hC0A8_0002, 32'h0000_0000, 32'hFFFF_FFFF};

        // defaults after reset
        dir_rows.push_back(known_row(OP_TICK, '0, '0, MODE_FREE, 1'b0, '0, 1'b0, '0));
        dir_rows.push_back(known_row(OP_RESOLVE, '0, '1, MODE_RESOLVING, 1'b1, '0, 1'b0, '0));
        dir_rows.push_back(known_row(OP_RESOLVE, '0, '0, MODE_RESOLVING, 1'b0, '0, 1'b0, '0));
        dir_rows.push_back(item_row(OP_TICK, '1, '1));
        dir_rows.push_back(known_row(OP_UPDATE, '1, '1, MODE_VALID, 1'b0, '0, 1'b0, '0));
        dir_rows.push_back(known_row(OP_RESOLVE, '1, '0, MODE_VALID, 1'b0, '0, 1'b1, '1));
        dir_rows.push_back(known_row(OP_RESOLVE, '0, '0, MODE_RESOLVING, 1'b1, '0, 1'b0, '0));
        dir_rows.push_back(known_row(OP_NONE, '1, '1, MODE_RESOLVING, 1'b0, '0, 1'b0, '0));
        // shortest timers: zero acts like one, retries value gets masked, index 3 ignored
        dir_rows.push_back(reg_row(CFG_VALID_TIMEOUT, 8'd1));
        dir_rows.push_back(reg_row(CFG_RESOLVE_TIMEOUT, 8'd0));
        dir_rows.push_back(reg_row(CFG_MAX_RETRIES, 8'hF1));
        dir_rows.push_back(reg_row(CFG_NO_REG, 8'hFF));
        dir_rows.push_back(item_row(OP_UPDATE, 32'h5555_AAAA, 48'hAAAA_5555_0F0F));
        dir_rows.push_back(item_row(OP_TICK, '0, '0));
        dir_rows.push_back(item_row(OP_TICK, '0, '0));
        dir_rows.push_back(item_row(OP_TICK, '0, '0));
        dir_rows.push_back(known_row(OP_TICK, '0, '0, MODE_FREE, 1'b0, '0, 1'b0, '0));
        dir_rows.push_back(item_row(OP_RESOLVE, 32'hAAAA_5555, '0));
        dir_rows.push_back(item_row(OP_UPDATE, 32'hAAAA_5555, 48'h5555_AAAA_F0F0));
        dir_rows.push_back(item_row(OP_RESOLVE, 32'hAAAA_5554, '1));
        dir_rows.push_back(item_row(OP_TICK, '0, '0));
        dir_rows.push_back(item_row(OP_TICK, '0, '0));
        // longest timers
        dir_rows.push_back(reg_row(CFG_VALID_TIMEOUT, 8'd255));
        dir_rows.push_back(reg_row(CFG_RESOLVE_TIMEOUT, 8'd255));
        dir_rows.push_back(reg_row(CFG_MAX_RETRIES, 8'd15));
        dir_rows.push_back(item_row(OP_UPDATE, 32'h8000_0001, 48'h8000_0000_0001));
        dir_rows.push_back(item_row(OP_TICK, '0, '0));
        dir_rows.push_back(item_row(OP_RESOLVE, 32'h8000_0001, '0));

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_REG)
                write_reg(dir_rows[k].reg_idx, dir_rows[k].reg_val);
            else
                push_item(dir_rows[k].op, dir_rows[k].ip, dir_rows[k].mac,
                          dir_rows[k].typed, dir_rows[k].want);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_VALID_TIMEOUT, 8'd255);
                    write_reg(CFG_RESOLVE_TIMEOUT, 8'd255);
                    write_reg(CFG_MAX_RETRIES, 8'd15);
                end
                1: begin
                    write_reg(CFG_VALID_TIMEOUT, 8'd0);
                    write_reg(CFG_RESOLVE_TIMEOUT, 8'd0);
                    write_reg(CFG_MAX_RETRIES, 8'd0);
                end
                2: begin
                    write_reg(CFG_VALID_TIMEOUT, 8'd1);
                    write_reg(CFG_RESOLVE_TIMEOUT, 8'd1);
                    write_reg(CFG_MAX_RETRIES, 8'hFF);
                    hold_off_req = 1'b1;
                end
                default: begin
                    write_reg(CFG_VALID_TIMEOUT, 8'($urandom_range(0, 6)));
                    write_reg(CFG_RESOLVE_TIMEOUT, 8'($urandom_range(0, 4)));
                    write_reg(CFG_MAX_RETRIES, 8'($urandom_range(0, 255)));
                    if (ph == 4)
                        write_reg(CFG_NO_REG, 8'($urandom_range(0, 255)));
                end
            endcase
            // run the final phase back to back on both sides
            if (ph == N_PHASES - 1) begin
                src_gaps = 1'b0;
                sink_stalls = 1'b0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 19);
                if (pick <= 10)
                    op = OP_TICK;
                else if (pick <= 13)
                    op = OP_UPDATE;
                else if (pick <= 18)
                    op = OP_RESOLVE;
                else
                    op = OP_NONE;
                // favour the stored address so hits and repeated resolves turn up
                case ($urandom_range(0, 3))
                    0: ip = ent_ip;
                    1: ip = ip_pool[$urandom_range(0, 3)];
                    default: ip = $urandom;
                endcase
                wide = {$urandom, $urandom};
                push_item(op, ip, wide[MAC_W-1:0], 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
